>>> rtl/core/lr_pkg.sv
// lr_pkg: shared widths, types and operation codes of the line rasterizer.
// Depends on nothing; used by the channel interfaces and line_rasterizer.
package lr_pkg;

    localparam int COORD_BITS = 12;
    // Decision term: 2*extent minus extent needs two bits above a coordinate plus sign
    localparam int DEC_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

endpackage

>>> rtl/core/lr_in_if.sv
// lr_in_if: command channel of the line rasterizer (load or step).
// Depends on lr_pkg.
interface lr_in_if
    import lr_pkg::*;
();
    logic   valid;
    logic   ready;
    t_op    operation;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, output operation, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input operation, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

>>> rtl/core/lr_out_if.sv
// lr_out_if: pixel channel of the line rasterizer.
// Depends on lr_pkg.
interface lr_out_if
    import lr_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last;

    modport source (output valid, output pixel_x, output pixel_y, output last, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last, output ready);
endinterface

>>> rtl/core/line_rasterizer.sv
// line_rasterizer: all-octant Bresenham line rasterizer, one pixel per step.
// Depends on lr_pkg, lr_in_if and lr_out_if.
//
//  channel  | dir | payload                                       | transaction
//  i_cmd    | in  | operation, start_x, start_y, end_x, end_y     | load or step
//  o_pix    | out | pixel_x, pixel_y, last                        | one pixel
//
// A step updates the line state with a few adds and a sign test and writes the pixel
// into the output register in the same cycle.
// A load produces no pixel; a step with no active line is dropped.
// Reset (synchronous, active low) leaves no line active and the output empty.
// i_cmd.ready is low only while a pixel waits in the output register and
// o_pix.ready is low; otherwise one command is taken every cycle.
module line_rasterizer
    import lr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    lr_in_if.sink    i_cmd,
    lr_out_if.source o_pix
);

    // line state
    t_coord r_cur_x,  n_cur_x;
    t_coord r_cur_y,  n_cur_y;
    t_coord r_stop_x, n_stop_x;
    t_coord r_stop_y, n_stop_y;
    t_dec   r_dec,    n_dec;
    t_coord r_dx,     n_dx;
    t_coord r_dy,     n_dy;
    logic   r_y_down, n_y_down;
    logic   r_steep,  n_steep;
    logic   r_active, n_active;

    // output register
    logic   r_out_valid, n_out_valid;
    t_coord r_pix_x,     n_pix_x;
    t_coord r_pix_y,     n_pix_y;
    logic   r_last,      n_last;

    logic   accept;
    logic   out_free;

    // load setup terms
    logic   swap;
    t_coord ax, ay, bx, by;
    t_coord ld_dx, ld_dy;
    logic   ld_y_down, ld_steep;
    t_dec   ld_dec;

    // step terms
    logic   fin;
    t_dec   dx2, dy2;
    t_coord y_next;

    assign out_free    = !r_out_valid || o_pix.ready;
    assign i_cmd.ready = out_free;
    assign accept      = i_cmd.valid && out_free;

    assign o_pix.valid   = r_out_valid;
    assign o_pix.pixel_x = r_pix_x;
    assign o_pix.pixel_y = r_pix_y;
    assign o_pix.last    = r_last;

    // endpoint ordering and initial error term
    always_comb begin
        swap = (i_cmd.end_x < i_cmd.start_x) ||
               ((i_cmd.end_x == i_cmd.start_x) && (i_cmd.end_y < i_cmd.start_y));
        ax = swap ? i_cmd.end_x   : i_cmd.start_x;
        ay = swap ? i_cmd.end_y   : i_cmd.start_y;
        bx = swap ? i_cmd.start_x : i_cmd.end_x;
        by = swap ? i_cmd.start_y : i_cmd.end_y;
        ld_dx     = bx - ax;
        ld_y_down = by < ay;
        ld_dy     = ld_y_down ? (ay - by) : (by - ay);
        ld_steep  = ld_dy > ld_dx;
        if (ld_steep) begin
            ld_dec = (t_dec'({3'b000, ld_dx}) <<< 1) - t_dec'({3'b000, ld_dy});
        end else begin
            ld_dec = (t_dec'({3'b000, ld_dy}) <<< 1) - t_dec'({3'b000, ld_dx});
        end
    end

    // one Bresenham step
    always_comb begin
        fin    = r_steep ? (r_cur_y == r_stop_y) : (r_cur_x == r_stop_x);
        dx2    = t_dec'({3'b000, r_dx}) <<< 1;
        dy2    = t_dec'({3'b000, r_dy}) <<< 1;
        y_next = r_y_down ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
    end

    // next state
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_stop_x    = r_stop_x;
        n_stop_y    = r_stop_y;
        n_dec       = r_dec;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_y_down    = r_y_down;
        n_steep     = r_steep;
        n_active    = r_active;
        n_out_valid = r_out_valid && !o_pix.ready;
        n_pix_x     = r_pix_x;
        n_pix_y     = r_pix_y;
        n_last      = r_last;

        if (accept) begin
            unique case (i_cmd.operation)
                OP_LOAD: begin
                    n_cur_x  = ax;
                    n_cur_y  = ay;
                    n_stop_x = bx;
                    n_stop_y = by;
                    n_dx     = ld_dx;
                    n_dy     = ld_dy;
                    n_y_down = ld_y_down;
                    n_steep  = ld_steep;
                    n_dec    = ld_dec;
                    n_active = 1'b1;
                end
                OP_STEP: begin
                    if (r_active) begin
                        n_out_valid = 1'b1;
                        n_pix_x     = r_cur_x;
                        n_pix_y     = r_cur_y;
                        n_last      = fin;
                        if (fin) begin
                            n_active = 1'b0;
                        end else if (r_steep) begin
                            n_cur_y = y_next;
                            if (!r_dec[DEC_BITS-1]) begin
                                n_cur_x = r_cur_x + 1'b1;
                                n_dec   = r_dec + dx2 - dy2;
                            end else begin
                                n_dec   = r_dec + dx2;
                            end
                        end else begin
                            n_cur_x = r_cur_x + 1'b1;
                            if (!r_dec[DEC_BITS-1]) begin
                                n_cur_y = y_next;
                                n_dec   = r_dec + dy2 - dx2;
                            end else begin
                                n_dec   = r_dec + dy2;
                            end
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_stop_x    <= '0;
            r_stop_y    <= '0;
            r_dec       <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_y_down    <= 1'b0;
            r_steep     <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_stop_x    <= n_stop_x;
            r_stop_y    <= n_stop_y;
            r_dec       <= n_dec;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_y_down    <= n_y_down;
            r_steep     <= n_steep;
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        r_pix_x <= n_pix_x;
        r_pix_y <= n_pix_y;
        r_last  <= n_last;
    end

endmodule
